### src/range_kth_smallest_query_top_macros.svh
// assertion macros for the range k-th smallest query block
`ifndef RANGE_KTH_SMALLEST_QUERY_TOP_MACROS_SVH
`define RANGE_KTH_SMALLEST_QUERY_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RKQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define RKQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/rkq_pkg.sv
// ----------------------------------------------------------------------------
// rkq_pkg
// shared types and constants of the range k-th smallest query block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rkq_pkg;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 9;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // per-cycle control broadcast along the cell row
    typedef struct packed {
        logic              load;
        logic              clear;
        logic [VALUE_W-1:0] prefix;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] bitsel;
    } cell_ctl_t;
endpackage
`default_nettype wire

### src/rkq_cell.sv
// ----------------------------------------------------------------------------
// rkq_cell
// one array position: holds its key and in-range flag, raises its vote for
// the count tree over the row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rkq_cell
(
    input  wire               clk,
    input  wire               rst_n,
    input  rkq_pkg::cell_ctl_t ctl,
    input  wire               sel,
    input  wire               in_range,
    input  wire [31:0]        load_key,
    output logic              hit
);
    import rkq_pkg::*;

    logic [31:0] key_reg;
    logic        act_reg;

    // element is in range, matches the current prefix and has the tested bit clear
    assign hit = act_reg && ((key_reg & ctl.mask) == ctl.prefix) && !(|(key_reg & ctl.bitsel));

    always_ff @(posedge clk)
    begin
        if (ctl.load && sel)
        begin
            key_reg <= load_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            act_reg <= in_range;
        end
    end
endmodule
`default_nettype wire

### src/range_kth_smallest_query_top.sv
// ----------------------------------------------------------------------------
// range_kth_smallest_query_top
// k-th smallest value over a loaded range of signed values
// ----------------------------------------------------------------------------
// use: load items (command 0) write one value per transaction and give no
// result. query items (command 1) give a one-based range and a rank; one
// result transaction carries the value and a not-found flag. a query runs
// a setup step on acceptance that marks the cells in range, then 32 radix
// steps (one key bit per cycle, the in-range count of keys with that bit
// clear under the prefix summed over the row of cells by an adder tree),
// and a done step that forms the result in the output register.
// items are handled one at a time; the result sits in an output register
// and the next item is taken while it waits. a stalled receiver holds the
// result; a following query then waits in its done state, blocking input,
// until that result is taken.
// cfg writes the length in use; write it only while idle.
// reset clears control and the length; stored values are undefined until
// loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "range_kth_smallest_query_top_macros.svh"
module range_kth_smallest_query_top
#(
    parameter int MAX_ELEMENTS = 256
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // command, element_index, element_value, left_index, right_index, rank_k
    input  wire [71:0] s_axis_tdata,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // kth_value, not_found
    output logic [39:0] m_axis_tdata,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [8:0]  cfg_data
);
    import rkq_pkg::*;

    localparam int N = (MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic        command;
    logic [7:0]  element_index;
    logic [31:0] element_value;
    logic [8:0]  left_index, right_index, rank_k;
    assign command       = s_axis_tdata[0];
    assign element_index = s_axis_tdata[8:1];
    assign element_value = s_axis_tdata[40:9];
    assign left_index    = s_axis_tdata[49:41];
    assign right_index   = s_axis_tdata[58:50];
    assign rank_k        = s_axis_tdata[67:59];

    logic [1:0]  state_reg, state_next;
    logic [5:0]  bit_reg;
    logic [8:0]  len_reg;
    logic [8:0]  k_reg;
    logic [31:0] prefix_reg, mask_reg;
    logic        ok_reg;
    logic        ovld_reg;
    logic [31:0] oval_reg;
    logic        onf_reg;
    logic        in_acc, out_acc;
    logic [9:0]  len_use;
    logic        ok_now;
    cell_ctl_t   ctl;
    logic [N-1:0] hit;
    logic [8:0]  vote_sum [0:510];
    logic [31:0] bitsel;

    assign len_use = (len_reg > 9'(N)) ? 10'(N) : {1'b0, len_reg};
    assign ok_now = (rank_k != 9'd0) && (left_index != 9'd0) && (left_index <= right_index)
        && ({1'b0, right_index} <= len_use)
        && ({1'b0, rank_k} <= ({1'b0, right_index} - {1'b0, left_index} + 10'd1));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata = {7'd0, onf_reg, oval_reg};

    assign bitsel = 32'd1 << bit_reg[4:0];
    assign ctl.load   = in_acc && (command == CMD_LOAD);
    assign ctl.clear  = in_acc && (command == CMD_QUERY);
    assign ctl.prefix = prefix_reg;
    assign ctl.mask   = mask_reg;
    assign ctl.bitsel = bitsel;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic        rng;
        assign rng = (10'(i) >= {1'b0, left_index} - 10'd1) && (10'(i) < {1'b0, right_index});
        rkq_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .sel      (element_index == 8'(i)),
            .in_range (rng),
            .load_key (element_value ^ 32'h8000_0000),
            .hit      (hit[i])
        );
    end

    // adder tree over the cell votes, root at index 0
    for (genvar i = 0; i < 256; i++)
    begin : g_leaf
        if (i < N)
        begin : g_used
            assign vote_sum[255+i] = {8'd0, hit[i]};
        end
        else
        begin : g_pad
            assign vote_sum[255+i] = 9'd0;
        end
    end
    for (genvar j = 0; j < 255; j++)
    begin : g_node
        assign vote_sum[j] = vote_sum[2*j+1] + vote_sum[2*j+2];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctl.clear) state_next = ST_RUN;
            ST_RUN:  if (bit_reg == 6'd0) state_next = ST_DONE;
            ST_DONE: if (!ovld_reg || m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= 9'd0;
            ovld_reg  <= 1'b0;
            bit_reg   <= 6'd0;
            k_reg     <= 9'd0;
            ok_reg    <= 1'b0;
            prefix_reg <= 32'd0;
            mask_reg  <= 32'd0;
            oval_reg  <= 32'd0;
            onf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                len_reg <= cfg_data;
            if ((state_reg == ST_DONE) && (!ovld_reg || m_axis_tready))
                ovld_reg <= 1'b1;
            else if (out_acc)
                ovld_reg <= 1'b0;
            if (ctl.clear)
            begin
                bit_reg    <= 6'd31;
                k_reg      <= rank_k;
                ok_reg     <= ok_now;
                prefix_reg <= 32'd0;
                mask_reg   <= 32'd0;
            end
            else if (state_reg == ST_RUN)
            begin
                // count of keys with this bit clear under the prefix
                if ((vote_sum[0] >= k_reg))
                begin
                    prefix_reg <= prefix_reg;
                end
                else
                begin
                    prefix_reg <= prefix_reg | bitsel;
                    k_reg <= k_reg - vote_sum[0];
                end
                mask_reg <= mask_reg | bitsel;
                if (bit_reg != 6'd0)
                    bit_reg <= bit_reg - 6'd1;
            end
            else if ((state_reg == ST_DONE) && (!ovld_reg || m_axis_tready))
            begin
                oval_reg <= ok_reg ? (prefix_reg ^ 32'h8000_0000) : 32'd0;
                onf_reg  <= !ok_reg;
            end
        end
    end

    `RKQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RKQ_ASSERT_IMP(a_no_take_busy, state_reg != ST_IDLE, !s_axis_tready)
    `RKQ_ASSERT_IMP(a_nf_zero, m_axis_tvalid && onf_reg, oval_reg == 32'd0)
endmodule
`default_nettype wire
